// ===== rtl/core/sgc_pkg.sv =====
// Shared types and constants for the signal gate with cooldown.
package sgc_pkg;

	localparam int unsigned TS_W      = 64;
	localparam int unsigned CONF_IN_W = 32;
	localparam int unsigned CONF_W    = 17;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned COOL_W    = 16;
	localparam int unsigned REASONS   = 5;
	localparam int unsigned REASON_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 17;

	localparam logic [CONF_W-1:0] Q16_ONE    = 17'h10000;
	localparam logic [TS_W-1:0]   TS_RESET   = {1'b1, {(TS_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONF_FLOOR = 2'd0,
		CFG_COOLDOWN   = 2'd1,
		CFG_STATS_EN   = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		VERDICT_EMIT      = 3'd0,
		VERDICT_WARMUP    = 3'd1,
		VERDICT_NONFINITE = 3'd2,
		VERDICT_THRESHOLD = 3'd3,
		VERDICT_COOLDOWN  = 3'd4,
		VERDICT_DUPLICATE = 3'd5
	} verdict_t;

	typedef struct packed {
		logic signed [TS_W-1:0]      timestamp;
		logic                        inputs_ok;
		logic                        warmed;
		logic                        confidence_ok;
		logic signed [CONF_IN_W-1:0] confidence;
	} sample_t;

	typedef struct packed {
		logic              emitted;
		logic [2:0]        verdict;
		logic [CONF_W-1:0] confidence_out;
		logic [CNT_W-1:0]  emit_total;
		logic [CNT_W-1:0]  drop_total;
		logic [CNT_W-1:0]  verdict_total;
	} result_t;

endpackage

// ===== rtl/core/sgc_sample_if.sv =====
// Valid/ready channel carrying one input sample word.
interface sgc_sample_if;
	logic              valid;
	logic              ready;
	sgc_pkg::sample_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sgc_result_if.sv =====
// Valid/ready channel carrying one verdict word.
interface sgc_result_if;
	logic              valid;
	logic              ready;
	sgc_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/signal_gate_with_cooldown_core.sv =====
// Signal gate with cooldown: qualifies timestamped confidence samples.
//
// sample: valid/ready channel, one word per timestamped confidence sample.
// result: valid/ready channel, exactly one verdict word per sample, in order.
// wr_en/wr_index/wr_data: register writes (min confidence, cooldown length,
// statistics enable); the user makes them only while no sample is in flight;
// the block itself does not enforce it. A taken sample sits in the input
// register; once the result register can advance, the gate decision is
// written into it, where the cooldown, last emitted time and counters update.
// Throughput is one sample per cycle while result.ready stays high; the only
// feedback is the state read and written within the decision stage.
// Reset clears the cooldown and counters, sets the last emitted time to the
// most negative value and restores register defaults; both stages empty.
// A stalled receiver holds the result word; the input stage fills behind it
// and sample.ready drops until result.ready returns.
module signal_gate_with_cooldown_core (
	input  logic                                clk,
	input  logic                                arst_n,
	sgc_sample_if.sink                          sample,
	sgc_result_if.source                        result,
	input  logic                                wr_en,
	input  logic [sgc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [sgc_pkg::CFG_DAT_W-1:0]       wr_data
);

	// configuration
	logic [sgc_pkg::CONF_W-1:0] conf_floor_q;
	logic [sgc_pkg::COOL_W-1:0] cooldown_samples_q;
	logic                       stats_en_q;

	// gate state
	logic [sgc_pkg::COOL_W-1:0]  cooldown_q;
	logic [sgc_pkg::TS_W-1:0]    last_ts_q;
	logic [sgc_pkg::CNT_W-1:0]   emit_cnt_q;
	logic [sgc_pkg::CNT_W-1:0]   drop_cnt_q;
	logic [sgc_pkg::CNT_W-1:0]   reason_cnt_q [sgc_pkg::REASONS];

	// pipeline
	logic              valid_s1;
	sgc_pkg::sample_t  sample_s1;
	logic              out_valid_q;
	sgc_pkg::result_t  result_q;

	logic advance;
	logic fire;

	logic [sgc_pkg::CONF_W-1:0]   conf_clamped;
	sgc_pkg::verdict_t            verdict_c;
	logic                         drop_c;
	logic [sgc_pkg::REASON_W-1:0] reason_idx;
	logic [sgc_pkg::CNT_W-1:0]    emit_next;
	logic [sgc_pkg::CNT_W-1:0]    drop_next;
	logic [sgc_pkg::CNT_W-1:0]    reason_next;

	assign advance      = !out_valid_q || result.ready;
	assign fire         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.data  = result_q;

	always_comb begin
		if (sample_s1.confidence[sgc_pkg::CONF_IN_W-1]) begin
			conf_clamped = '0;
		end else if (sample_s1.confidence > signed'({15'd0, sgc_pkg::Q16_ONE})) begin
			conf_clamped = sgc_pkg::Q16_ONE;
		end else begin
			conf_clamped = sample_s1.confidence[sgc_pkg::CONF_W-1:0];
		end
	end

	always_comb begin
		if (!sample_s1.inputs_ok) begin
			verdict_c = sgc_pkg::VERDICT_NONFINITE;
		end else if (!sample_s1.warmed) begin
			verdict_c = sgc_pkg::VERDICT_WARMUP;
		end else if (!sample_s1.confidence_ok) begin
			verdict_c = sgc_pkg::VERDICT_NONFINITE;
		end else if (conf_clamped < conf_floor_q) begin
			verdict_c = sgc_pkg::VERDICT_THRESHOLD;
		end else if (cooldown_q != '0) begin
			verdict_c = sgc_pkg::VERDICT_COOLDOWN;
		end else if (last_ts_q == sample_s1.timestamp) begin
			verdict_c = sgc_pkg::VERDICT_DUPLICATE;
		end else begin
			verdict_c = sgc_pkg::VERDICT_EMIT;
		end
	end

	assign drop_c = verdict_c != sgc_pkg::VERDICT_EMIT;

	// reason slots hold verdicts one to five
	assign reason_idx = drop_c ? (verdict_c - 3'd1) : '0;

	assign emit_next   = emit_cnt_q + {{(sgc_pkg::CNT_W-1){1'b0}}, !drop_c && stats_en_q};
	assign drop_next   = drop_cnt_q + {{(sgc_pkg::CNT_W-1){1'b0}}, drop_c && stats_en_q};
	assign reason_next = reason_cnt_q[reason_idx]
		+ {{(sgc_pkg::CNT_W-1){1'b0}}, drop_c && stats_en_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_floor_q       <= '0;
			cooldown_samples_q <= '0;
			stats_en_q         <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				sgc_pkg::CFG_CONF_FLOOR: conf_floor_q <= wr_data;
				sgc_pkg::CFG_COOLDOWN: cooldown_samples_q <= wr_data[sgc_pkg::COOL_W-1:0];
				sgc_pkg::CFG_STATS_EN: stats_en_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cooldown_q  <= '0;
			last_ts_q   <= sgc_pkg::TS_RESET;
			emit_cnt_q  <= '0;
			drop_cnt_q  <= '0;
			for (int i = 0; i < sgc_pkg::REASONS; i++) begin
				reason_cnt_q[i] <= '0;
			end
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				emit_cnt_q <= emit_next;
				drop_cnt_q <= drop_next;
				if (drop_c) begin
					reason_cnt_q[reason_idx] <= reason_next;
				end
				if (verdict_c == sgc_pkg::VERDICT_COOLDOWN) begin
					cooldown_q <= cooldown_q - 16'd1;
				end else if (!drop_c) begin
					cooldown_q <= cooldown_samples_q;
					last_ts_q  <= sample_s1.timestamp;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample.data;
		end
		if (fire) begin
			result_q.emitted        <= !drop_c;
			result_q.verdict        <= verdict_c;
			result_q.confidence_out <= drop_c ? '0 : conf_clamped;
			result_q.emit_total     <= emit_next;
			result_q.drop_total     <= drop_next;
			result_q.verdict_total  <= drop_c ? reason_next : '0;
		end
	end

	a_emit_matches_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.emitted == (result_q.verdict == sgc_pkg::VERDICT_EMIT)))
		else $error("emitted flag disagrees with verdict");

	a_drop_zero_conf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_q.emitted) |->
			(result_q.confidence_out == '0 && result_q.verdict_total != '0 || !stats_en_q
			|| result_q.confidence_out == '0))
		else $error("dropped word carries a confidence");

	a_emit_reloads_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !drop_c) |=> (cooldown_q == $past(cooldown_samples_q)
			&& last_ts_q == $past(sample_s1.timestamp)))
		else $error("emission did not reload cooldown");

	a_cooldown_only_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && verdict_c == sgc_pkg::VERDICT_COOLDOWN) |=>
			(cooldown_q == $past(cooldown_q) - 16'd1))
		else $error("cooldown did not decrement");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(!fire && !wr_en) |=> ($stable(cooldown_q) && $stable(emit_cnt_q)
			&& $stable(drop_cnt_q)))
		else $error("gate state moved without a word");

endmodule

// ===== sim/gate_verdict_checker.sv =====
// Verdict checker for the signal gate: tracks gate state, predicts each verdict word, compares.
module gate_verdict_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_ready,
	input  sgc_pkg::sample_t              sample_data,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  sgc_pkg::result_t              result_data,
	input  logic                          wr_en,
	input  logic [sgc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [sgc_pkg::CFG_DAT_W-1:0] wr_data,
	output int                            mismatches,
	output int                            outstanding,
	output int                            words_checked,
	output int                            words_emitted,
	output logic [5:0]                    verdicts_hit
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copies
	logic [sgc_pkg::CONF_W-1:0] conf_floor;
	logic [sgc_pkg::COOL_W-1:0] cool_len;
	logic                       stats_on;

	// gate state
	logic [sgc_pkg::COOL_W-1:0] cool_left;
	logic [sgc_pkg::TS_W-1:0]   last_emit_ts;
	logic [sgc_pkg::CNT_W-1:0]  emit_cnt;
	logic [sgc_pkg::CNT_W-1:0]  drop_cnt;
	logic [sgc_pkg::CNT_W-1:0]  reason_cnt [1:sgc_pkg::REASONS];

	sgc_pkg::result_t  expected_verdicts [$];
	sgc_pkg::result_t  oldest;
	sgc_pkg::result_t  predicted;

	task automatic gate_sample(input sgc_pkg::sample_t s, output sgc_pkg::result_t r);
		sgc_pkg::verdict_t          v;
		logic [sgc_pkg::CONF_W-1:0] conf;
		logic [31:0]                raw;
		v = sgc_pkg::VERDICT_EMIT;
		conf = '0;
		raw = s.confidence;
		r = '0;
		if (!s.inputs_ok) begin
			v = sgc_pkg::VERDICT_NONFINITE;
		end else if (!s.warmed) begin
			v = sgc_pkg::VERDICT_WARMUP;
		end else if (!s.confidence_ok) begin
			v = sgc_pkg::VERDICT_NONFINITE;
		end else begin
			// clamp signed Q15.16 into 0..1.0
			if (raw[31])
				conf = '0;
			else if (raw > 32'h0001_0000)
				conf = sgc_pkg::Q16_ONE;
			else
				conf = raw[sgc_pkg::CONF_W-1:0];

			if (conf < conf_floor) begin
				v = sgc_pkg::VERDICT_THRESHOLD;
			end else if (cool_left != '0) begin
				cool_left = cool_left - 1'b1;
				v = sgc_pkg::VERDICT_COOLDOWN;
			end else if (last_emit_ts == s.timestamp) begin
				v = sgc_pkg::VERDICT_DUPLICATE;
			end else begin
				last_emit_ts = s.timestamp;
				cool_left = cool_len;
				if (stats_on)
					emit_cnt = emit_cnt + 1'b1;
			end
		end

		if (v != sgc_pkg::VERDICT_EMIT) begin
			if (stats_on) begin
				drop_cnt = drop_cnt + 1'b1;
				reason_cnt[v] = reason_cnt[v] + 1'b1;
			end
			r.verdict_total = reason_cnt[v];
			conf = '0;
		end
		r.emitted = (v == sgc_pkg::VERDICT_EMIT);
		r.verdict = v;
		r.confidence_out = conf;
		r.emit_total = emit_cnt;
		r.drop_total = drop_cnt;
	endtask

	task automatic compare_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_floor = '0;
			cool_len = '0;
			stats_on = 1'b1;
			cool_left = '0;
			last_emit_ts = sgc_pkg::TS_RESET;
			emit_cnt = '0;
			drop_cnt = '0;
			for (int i = 1; i <= sgc_pkg::REASONS; i++)
				reason_cnt[i] = '0;
			expected_verdicts.delete();
			mismatches = 0;
			outstanding = 0;
			words_checked = 0;
			words_emitted = 0;
			verdicts_hit = '0;
		end else begin
			// retire first so a word never meets an expectation queued at the same edge
			if (result_valid && result_ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("verdict word arrived with no sample outstanding");
					mismatches++;
				end else begin
					oldest = expected_verdicts.pop_front();
					compare_field("emitted", 64'(oldest.emitted), 64'(result_data.emitted));
					compare_field("verdict", 64'(oldest.verdict), 64'(result_data.verdict));
					compare_field("confidence_out", 64'(oldest.confidence_out),
						64'(result_data.confidence_out));
					compare_field("emit_total", 64'(oldest.emit_total),
						64'(result_data.emit_total));
					compare_field("drop_total", 64'(oldest.drop_total),
						64'(result_data.drop_total));
					compare_field("verdict_total", 64'(oldest.verdict_total),
						64'(result_data.verdict_total));
					words_checked++;
					if (oldest.emitted)
						words_emitted++;
					verdicts_hit[oldest.verdict] = 1'b1;
				end
			end

			if (wr_en) begin
				case (sgc_pkg::cfg_index_t'(wr_index))
					sgc_pkg::CFG_CONF_FLOOR: conf_floor = wr_data[sgc_pkg::CONF_W-1:0];
					sgc_pkg::CFG_COOLDOWN: cool_len = wr_data[sgc_pkg::COOL_W-1:0];
					sgc_pkg::CFG_STATS_EN: stats_on = wr_data[0];
					default: ;
				endcase
			end

			if (sample_valid && sample_ready) begin
				gate_sample(sample_data, predicted);
				expected_verdicts.push_back(predicted);
			end

			outstanding = expected_verdicts.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the signal gate: clock, reset, sample and register stimulus, verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          HOLD_CYCLES = 60;
	localparam logic [63:0] TS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          wr_en = 1'b0;
	logic [sgc_pkg::CFG_IDX_W-1:0] wr_index = '0;
	logic [sgc_pkg::CFG_DAT_W-1:0] wr_data = '0;

	logic                          hold_request = 1'b0;
	logic                          hold_done = 1'b0;
	logic [63:0]                   ts_cursor = 64'd1000;
	logic [63:0]                   last_ts = sgc_pkg::TS_RESET;
	logic [sgc_pkg::CONF_W-1:0]    cur_min = '0;
	int                            samples_sent = 0;
	int                            settings_used = 0;

	int                            mismatches;
	int                            outstanding;
	int                            words_checked;
	int                            words_emitted;
	logic [5:0]                    verdicts_hit;

	sgc_sample_if sample_ch ();
	sgc_result_if result_ch ();

	signal_gate_with_cooldown_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	gate_verdict_checker verdict_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_ch.valid),
		.sample_ready  (sample_ch.ready),
		.sample_data   (sample_ch.data),
		.result_valid  (result_ch.valid),
		.result_ready  (result_ch.ready),
		.result_data   (result_ch.data),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked),
		.words_emitted (words_emitted),
		.verdicts_hit  (verdicts_hit)
	);

	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic sgc_pkg::sample_t pack_sample(input logic [63:0] ts, input logic ok,
			input logic warm, input logic conf_ok, input logic [31:0] conf);
		sgc_pkg::sample_t s;
		s.timestamp = ts;
		s.inputs_ok = ok;
		s.warmed = warm;
		s.confidence_ok = conf_ok;
		s.confidence = conf;
		return s;
	endfunction

	task automatic offer(input sgc_pkg::sample_t s);
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		samples_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			sample_ch.valid <= 1'b0;
		end
	endtask

	task automatic set_reg(input sgc_pkg::cfg_index_t idx,
			input logic [sgc_pkg::CFG_DAT_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// registers change only with the gate empty
	task automatic apply_settings(input logic [sgc_pkg::CONF_W-1:0] min_c,
			input logic [15:0] cool, input logic stats);
		pause_sender(1);
		wait (outstanding == 0);
		set_reg(sgc_pkg::CFG_CONF_FLOOR, min_c);
		set_reg(sgc_pkg::CFG_COOLDOWN, {1'b0, cool});
		set_reg(sgc_pkg::CFG_STATS_EN, {16'd0, stats});
		cur_min = min_c;
		settings_used++;
	endtask

	task automatic run_random(input int count);
		sgc_pkg::sample_t s;
		int               burst_left;
		int               pick;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(3) != 0)
					pause_sender($urandom_range(1, 8));
			end
			burst_left--;

			s.inputs_ok = ($urandom_range(9) != 0);
			s.warmed = ($urandom_range(9) != 0);
			s.confidence_ok = ($urandom_range(9) != 0);

			// repeats of the last timestamp drive the duplicate check
			pick = $urandom_range(99);
			if (pick < 25) begin
				s.timestamp = last_ts;
			end else if (pick < 30) begin
				s.timestamp = pick[0] ? sgc_pkg::TS_RESET : TS_MAX;
			end else if (pick < 50) begin
				s.timestamp = {$urandom, $urandom};
			end else begin
				ts_cursor = ts_cursor + $urandom_range(1, 3);
				s.timestamp = ts_cursor;
			end
			last_ts = s.timestamp;

			pick = $urandom_range(99);
			if (pick < 55) begin
				s.confidence = $urandom_range(0, 65536);
			end else if (pick < 70) begin
				case ($urandom_range(3))
					0: s.confidence = 32'd0;
					1: s.confidence = 32'd65535;
					2: s.confidence = 32'd65536;
					default: s.confidence = 32'd65537;
				endcase
			end else if (pick < 85) begin
				s.confidence = cur_min + $urandom_range(0, 4) - 2;
			end else begin
				s.confidence = $urandom;
			end
			offer(s);
		end
	endtask

	// receiver: random ready pattern, or one long hold-off on request
	initial begin : receiver
		int pct;
		int left;
		pct = 100;
		left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				if (left == 0) begin
					case ($urandom_range(3))
						0: pct = 100;
						1: pct = 75;
						2: pct = 40;
						default: pct = 15;
					endcase
					left = $urandom_range(8, 64);
				end
				left--;
				result_ch.ready <= ($urandom_range(99) < pct);
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: no threshold, no cooldown, statistics on
		offer(pack_sample(sgc_pkg::TS_RESET, 1'b1, 1'b1, 1'b1, 32'd1000));
		offer(pack_sample(64'd5, 1'b0, 1'b0, 1'b0, 32'd0));
		offer(pack_sample(64'd5, 1'b1, 1'b0, 1'b0, 32'd0));
		offer(pack_sample(64'd5, 1'b1, 1'b1, 1'b0, 32'd0));
		offer(pack_sample(64'd1, 1'b1, 1'b1, 1'b1, 32'h8000_0000));
		offer(pack_sample(64'd2, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF));
		offer(pack_sample(64'd3, 1'b1, 1'b1, 1'b1, 32'd65537));
		offer(pack_sample(64'd4, 1'b1, 1'b1, 1'b1, 32'd65535));
		offer(pack_sample(64'd4, 1'b1, 1'b1, 1'b1, 32'd65536));
		offer(pack_sample(TS_MAX, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
		offer(pack_sample(sgc_pkg::TS_RESET, 1'b1, 1'b1, 1'b1, 32'd0));
		offer(pack_sample(sgc_pkg::TS_RESET, 1'b1, 1'b1, 1'b1, 32'd0));

		// threshold above one
		apply_settings(17'h1FFFF, 16'd0, 1'b1);
		offer(pack_sample(64'd20, 1'b1, 1'b1, 1'b1, 32'd65536));
		offer(pack_sample(64'd21, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF));
		offer(pack_sample(64'd22, 1'b1, 1'b1, 1'b0, 32'd65536));

		// cooldown with statistics frozen
		apply_settings(17'd32768, 16'd2, 1'b0);
		offer(pack_sample(64'd30, 1'b1, 1'b1, 1'b1, 32'd32768));
		offer(pack_sample(64'd31, 1'b1, 1'b1, 1'b1, 32'd40000));
		offer(pack_sample(64'd32, 1'b1, 1'b1, 1'b1, 32'd32767));
		offer(pack_sample(64'd33, 1'b1, 1'b1, 1'b1, 32'd65536));
		offer(pack_sample(64'd30, 1'b1, 1'b1, 1'b1, 32'd50000));
		offer(pack_sample(64'd34, 1'b1, 1'b1, 1'b1, 32'd50000));
		offer(pack_sample(64'd35, 1'b1, 1'b0, 1'b1, 32'd50000));

		apply_settings(17'd0, 16'd0, 1'b1);
		run_random(100);

		apply_settings(17'd65536, 16'd0, 1'b1);
		run_random(100);

		// long receiver hold-off while words keep coming, so the input stalls
		apply_settings(17'd49152, 16'd1, 1'b1);
		hold_request = 1'b1;
		for (int k = 0; k < 40; k++) begin
			ts_cursor = ts_cursor + 1'b1;
			offer(pack_sample(ts_cursor, 1'b1, 1'b1, 1'b1, $urandom_range(40000, 65536)));
		end
		run_random(60);

		apply_settings(17'h1FFFF, 16'd3, 1'b1);
		run_random(100);

		apply_settings(17'($urandom_range(0, 65536)), 16'($urandom_range(0, 4)),
			1'($urandom_range(0, 1)));
		run_random(100);

		apply_settings(17'($urandom_range(0, 131071)), 16'($urandom_range(0, 2)), 1'b0);
		run_random(100);

		// longest cooldown last: it outlasts the rest of the run
		apply_settings(17'd0, 16'hFFFF, 1'b1);
		run_random(100);

		pause_sender(1);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d samples under %0d register settings; %0d verdict words checked.",
			samples_sent, settings_used + 1, words_checked);
		$display("%0d samples emitted; verdict codes seen (bit per code, 5..0): %b",
			words_emitted, verdicts_hit);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
